@@ sv/lss_pkg.sv @@
// ----------------------------------------------------------------------------
// lss_pkg
// Shared types and constants for the bounded stack with in-place sort.
// ----------------------------------------------------------------------------
`default_nettype none

package lss_pkg;

    localparam int DEF_CAPACITY = 32;
    localparam int WORD_W       = 32;
    localparam int DEPTH_W      = 6;

    typedef enum logic [1:0] {
        OP_PUSH = 2'd0,
        OP_POP  = 2'd1,
        OP_SORT = 2'd2,
        OP_NOP  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2,
        ST_RSVD      = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        CELL_HOLD = 2'd0,
        CELL_PUSH = 2'd1,
        CELL_POP  = 2'd2,
        CELL_SORT = 2'd3
    } t_cell_op;

    // command broadcast to every cell of the chain
    typedef struct packed {
        t_cell_op op;
        logic     phase;
    } t_cell_cmd;

    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_SORT = 2'd1,
        S_FIN  = 2'd2
    } t_state;

endpackage

`default_nettype wire

@@ sv/lifo_stack_with_sort.sv @@
// ----------------------------------------------------------------------------
// lifo_stack_with_sort
// Bounded stack of signed words held in a chain of cells, with push, pop
// and an ascending in-place sort (largest on top).
// ----------------------------------------------------------------------------
// Push, pop and the unused op code may follow back to back while the output
// is not stalled; every item gives one result in a registered output stage.
// A sort of n held entries (at most CAPACITY) runs n odd-even transposition
// steps across the cell chain, one step per cycle, then posts the result once
// the output is free; intake stops until then. A sort of fewer than two
// entries runs no steps and gives its result as a push or pop does.
// ----------------------------------------------------------------------------
`default_nettype none

module lifo_stack_with_sort
    import lss_pkg::*;
#(
    parameter int CAPACITY = DEF_CAPACITY
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_in_valid,
    output logic                          o_in_stall,
    input  wire logic [1:0]               i_op,
    input  wire logic signed [WORD_W-1:0] i_push_value,
    output logic                          o_out_valid,
    input  wire logic                     i_out_stall,
    output logic signed [WORD_W-1:0]      o_popped_value,
    output logic signed [WORD_W-1:0]      o_top_value,
    output logic [DEPTH_W-1:0]            o_depth_now,
    output logic [1:0]                    o_status,
    output logic                          o_is_full,
    output logic                          o_is_empty
);

    localparam int CW = $clog2(CAPACITY + 1);

    logic signed [WORD_W-1:0] w_value [CAPACITY];

    t_state    r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_pass, n_pass;
    logic      r_out_valid, n_out_valid;
    t_cell_cmd w_cmd;

    logic signed [WORD_W-1:0] r_popped, n_popped;
    logic signed [WORD_W-1:0] r_top, n_top;
    logic [CW-1:0]            r_depth, n_depth;
    t_status                  r_status, n_status;

    logic                     w_accept;
    logic                     w_out_free;
    logic [CW+DEPTH_W-1:0]    w_depth_ext;

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
            logic signed [WORD_W-1:0] w_above;
            logic signed [WORD_W-1:0] w_below;
            if (gi == 0) begin : g_first
                assign w_above = i_push_value;
            end else begin : g_mid_a
                assign w_above = w_value[gi-1];
            end
            if (gi == CAPACITY - 1) begin : g_last
                assign w_below = '0;
            end else begin : g_mid_b
                assign w_below = w_value[gi+1];
            end
            lss_cell #(
                .IDX (gi),
                .CW  (CW)
            ) u_cell (
                .i_clk   (i_clk),
                .i_cmd   (w_cmd),
                .i_count (r_count),
                .i_above (w_above),
                .i_below (w_below),
                .o_value (w_value[gi])
            );
        end
    endgenerate

    assign w_out_free = !r_out_valid || !i_out_stall;
    assign o_in_stall = !((r_state == S_IDLE) && w_out_free);
    assign w_accept   = i_in_valid && !o_in_stall;

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_pass      = r_pass;
        n_out_valid = r_out_valid && i_out_stall;
        n_popped    = r_popped;
        n_top       = r_top;
        n_depth     = r_depth;
        n_status    = r_status;
        w_cmd.op    = CELL_HOLD;
        w_cmd.phase = r_pass[0];

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_popped = '0;
                    n_status = ST_DONE;
                    n_top    = w_value[0];
                    if (i_op == OP_PUSH) begin
                        if (r_count >= CW'(CAPACITY)) begin
                            n_status = ST_OVERFLOW;
                        end else begin
                            w_cmd.op = CELL_PUSH;
                            n_count  = r_count + 1'b1;
                            n_top    = i_push_value;
                        end
                    end else if (i_op == OP_POP) begin
                        if (r_count == '0) begin
                            n_status = ST_UNDERFLOW;
                        end else begin
                            w_cmd.op = CELL_POP;
                            n_count  = r_count - 1'b1;
                            n_popped = w_value[0];
                            n_top    = w_value[1];
                        end
                    end
                    if (n_count == '0) begin
                        n_top = '0;
                    end
                    n_depth = n_count;
                    if ((i_op == OP_SORT) && (r_count > CW'(1))) begin
                        n_state = S_SORT;
                        n_pass  = '0;
                    end else begin
                        n_out_valid = 1'b1;
                    end
                end
            end
            S_SORT: begin
                w_cmd.op = CELL_SORT;
                n_pass   = r_pass + 1'b1;
                if (r_pass == r_count - 1'b1) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (w_out_free) begin
                    n_top       = w_value[0];
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_pass      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_pass      <= n_pass;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_popped <= n_popped;
        r_top    <= n_top;
        r_depth  <= n_depth;
        r_status <= n_status;
    end

    assign w_depth_ext    = {{DEPTH_W{1'b0}}, r_depth};
    assign o_out_valid    = r_out_valid;
    assign o_popped_value = r_popped;
    assign o_top_value    = r_top;
    assign o_depth_now    = w_depth_ext[DEPTH_W-1:0];
    assign o_status       = r_status;
    assign o_is_full      = r_depth == CW'(CAPACITY);
    assign o_is_empty     = r_depth == '0;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("held count above capacity");

    a_sort_count_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SORT) |=> $stable(r_count))
        else $error("count changed during sort");

    a_overflow_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_status == ST_OVERFLOW)) |-> o_is_full)
        else $error("overflow reported while not full");

    a_underflow_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_status == ST_UNDERFLOW)) |-> (o_is_empty && (r_popped == '0)))
        else $error("underflow reported with entries held");

endmodule

`default_nettype wire

@@ sv/lss_cell.sv @@
// ----------------------------------------------------------------------------
// lss_cell
// One stack entry. Shifts down on push, up on pop, and does one
// compare-exchange with a neighbor per odd-even transposition step.
// ----------------------------------------------------------------------------
`default_nettype none

module lss_cell
    import lss_pkg::*;
#(
    parameter int IDX = 0,
    parameter int CW  = 6
) (
    input  wire logic                     i_clk,
    input  wire t_cell_cmd                i_cmd,
    input  wire logic [CW-1:0]            i_count,
    input  wire logic signed [WORD_W-1:0] i_above,
    input  wire logic signed [WORD_W-1:0] i_below,
    output logic signed [WORD_W-1:0]      o_value
);

    localparam logic PAR = (IDX % 2) != 0;

    logic signed [WORD_W-1:0] r_value;
    logic signed [WORD_W-1:0] n_value;
    logic                     w_below_held;
    logic                     w_self_held;

    // index 0 is the top of the stack
    assign w_below_held = i_count > CW'(IDX + 1);
    assign w_self_held  = i_count > CW'(IDX);

    always_comb begin
        n_value = r_value;
        case (i_cmd.op)
            CELL_PUSH: n_value = i_above;
            CELL_POP:  n_value = i_below;
            CELL_SORT: begin
                if (PAR == i_cmd.phase) begin
                    // upper of the pair keeps the larger word
                    if (w_below_held && (i_below > r_value)) begin
                        n_value = i_below;
                    end
                end else begin
                    if ((IDX > 0) && w_self_held && (i_above < r_value)) begin
                        n_value = i_above;
                    end
                end
            end
            default: n_value = r_value;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value = r_value;

endmodule

`default_nettype wire
